FILE: rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int MAX_ORDERS_DEF = 32;
  localparam int Q_DEPTH        = 2;

  typedef enum logic [1:0] {
    OP_LIMIT  = 2'd0,
    OP_MARKET = 2'd1,
    OP_CANCEL = 2'd2,
    OP_MODIFY = 2'd3
  } op_t;

  localparam logic [2:0] ST_RESTED    = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_MKT_DONE  = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_IGNORED   = 3'd6;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_SUM   = 1'b1;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    op_t         op;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] id;
    logic [47:0] ts;
  } cmd_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SCAN,
    E_TRADE,
    E_SUMMARY
  } eng_state_t;

  typedef enum logic [1:0] {
    PH_MATCH,
    PH_CANCEL,
    PH_SUMMARY
  } phase_t;

endpackage

FILE: rtl/lobm_front.sv
// ----------------------------------------------------------------------------
// lobm_front
// Accepts commands, decodes the mode and queues them for the engine.
// ----------------------------------------------------------------------------
module lobm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic [1:0]          mode,
  input  logic                side,
  input  logic [31:0]         price,
  input  logic [31:0]         quantity,
  input  logic [31:0]         order_id,
  input  logic [47:0]         timestamp,
  output logic                q_valid,
  output lobm_pkg::cmd_t      q_cmd,
  input  logic                q_pop
);
  import lobm_pkg::*;

  localparam int QW = $clog2(Q_DEPTH);

  cmd_t            entry [Q_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [QW:0]     count;
  cmd_t            dec;
  logic            push;
  logic            pop;

  always_comb begin
    dec.op    = op_t'(mode);
    dec.side  = side;
    dec.price = price;
    dec.qty   = quantity;
    dec.id    = order_id;
    dec.ts    = timestamp;
  end

  assign cmd_stall = (count == (QW+1)'(Q_DEPTH));
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QW'(Q_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QW'(Q_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= dec;
  end

endmodule

FILE: rtl/lobm_engine.sv
// ----------------------------------------------------------------------------
// lobm_engine
// Executes queued commands against the order store by repeated slot scans.
// ----------------------------------------------------------------------------
module lobm_engine #(
  parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  lobm_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                kind,
  output logic [31:0]         trade_price,
  output logic [31:0]         trade_quantity,
  output logic [31:0]         resting_id,
  output logic [31:0]         taker_id,
  output logic [47:0]         trade_time,
  output logic [2:0]          status,
  output logic [31:0]         best_bid,
  output logic [31:0]         best_ask,
  output logic [31:0]         bid_total,
  output logic [31:0]         ask_total,
  output logic                last,
  output logic [$clog2(MAX_ORDERS+1)-1:0] fill_count
);
  import lobm_pkg::*;

  localparam int AW = $clog2(MAX_ORDERS);
  localparam int CW = $clog2(MAX_ORDERS+1);

  // order store
  logic        mem_side  [MAX_ORDERS];
  logic [31:0] mem_price [MAX_ORDERS];
  logic [31:0] mem_rem   [MAX_ORDERS];
  logic [31:0] mem_owner [MAX_ORDERS];
  logic [31:0] mem_arr   [MAX_ORDERS];
  logic [MAX_ORDERS-1:0] slot_valid;
  logic [31:0] arrival_counter;

  eng_state_t  state, state_next;
  phase_t      phase;
  cmd_t        cur;
  logic [31:0] rem;
  logic [CW-1:0] nfill;
  logic [2:0]  stat;

  // scan pipeline
  logic [CW-1:0] cnt;
  logic          rd_vld;
  logic          rd_slotv;
  logic          rd_side;
  logic [31:0]   rd_price, rd_rem, rd_owner, rd_arr;
  logic [AW-1:0] rd_idx;

  // per-side best and level total
  logic          bfound [2];
  logic [31:0]   bprice [2];
  logic [31:0]   bage   [2];
  logic [AW-1:0] bidx   [2];
  logic [31:0]   brem   [2];
  logic [31:0]   bowner [2];
  logic [31:0]   btot   [2];
  // cancel target
  logic          hfound;
  logic [31:0]   hage;
  logic [AW-1:0] hidx;

  // control strobes
  logic start_scan, pop_cmd, do_trade, do_finish, emit_sum;
  logic out_free, scan_done, issue, go_fill;
  logic opp;
  logic [31:0] m;
  logic [31:0] age;
  logic better, same, take, hit;
  logic [32:0] tot_sum;
  logic [31:0] tot_new;
  logic          has_free;
  logic [AW-1:0] free_idx;
  logic [2:0]    fin_status;
  logic          do_rest;

  assign out_free  = !res_valid || !res_stall;
  assign issue     = (state == E_SCAN) && (cnt < CW'(MAX_ORDERS));
  assign scan_done = (state == E_SCAN) && (cnt == CW'(MAX_ORDERS)) && !rd_vld;
  assign opp       = ~cur.side;
  assign m         = (rem < brem[opp]) ? rem : brem[opp];
  assign fill_count = nfill;

  assign go_fill = (rem != '0) && (nfill < CW'(MAX_ORDERS)) && bfound[opp] &&
                   ((cur.op == OP_MARKET) ||
                    ((cur.side == SIDE_BUY)  && (cur.price >= bprice[opp])) ||
                    ((cur.side == SIDE_SELL) && (cur.price <= bprice[opp])));

  // lowest free slot
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        has_free = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  // compare one scanned slot against the running best of its side
  always_comb begin
    age     = arrival_counter - rd_arr;
    same    = bfound[rd_side] && (rd_price == bprice[rd_side]);
    better  = !bfound[rd_side] ||
              ((rd_side == SIDE_BUY)  && (rd_price > bprice[rd_side])) ||
              ((rd_side == SIDE_SELL) && (rd_price < bprice[rd_side]));
    take    = better || (same && (age > bage[rd_side]));
    tot_sum = {1'b0, btot[rd_side]} + {1'b0, rd_rem};
    tot_new = better ? rd_rem :
              same   ? (tot_sum[32] ? '1 : tot_sum[31:0]) : btot[rd_side];
    hit     = (rd_owner == cur.id) && (!hfound || (age < hage));
  end

  always_comb begin
    priority if (cur.op == OP_MARKET) fin_status = ST_MKT_DONE;
    else if (rem == '0)               fin_status = ST_FILLED;
    else if (has_free)                fin_status = ST_RESTED;
    else                              fin_status = ST_FULL;
  end
  assign do_rest = do_finish && (phase == PH_MATCH) && (fin_status == ST_RESTED);

  always_ff @(posedge clk) begin
    if (rst) state <= E_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    start_scan = 1'b0;
    pop_cmd    = 1'b0;
    do_trade   = 1'b0;
    do_finish  = 1'b0;
    emit_sum   = 1'b0;
    unique case (state)
      E_IDLE: begin
        if (q_valid) begin
          pop_cmd    = 1'b1;
          start_scan = 1'b1;
          state_next = E_SCAN;
        end
      end
      E_SCAN: begin
        if (scan_done) begin
          unique case (phase)
            PH_MATCH: begin
              if (go_fill) begin
                state_next = E_TRADE;
              end else begin
                do_finish  = 1'b1;
                start_scan = 1'b1;
              end
            end
            PH_CANCEL: begin
              do_finish  = 1'b1;
              start_scan = 1'b1;
            end
            default: state_next = E_SUMMARY;
          endcase
        end
      end
      E_TRADE: begin
        if (out_free) begin
          do_trade   = 1'b1;
          start_scan = 1'b1;
          state_next = E_SCAN;
        end
      end
      E_SUMMARY: begin
        if (out_free) begin
          emit_sum   = 1'b1;
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  assign q_pop = pop_cmd;

  // command context, scan control, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      arrival_counter <= '0;
      cnt             <= '0;
      rd_vld          <= 1'b0;
      nfill           <= '0;
      phase           <= PH_SUMMARY;
    end else begin
      // a scan never starts while one is issuing, so rd_vld drops here
      if (issue) begin
        cnt      <= cnt + 1'b1;
        rd_vld   <= 1'b1;
        rd_slotv <= slot_valid[cnt[AW-1:0]];
        rd_idx   <= cnt[AW-1:0];
      end else begin
        rd_vld <= 1'b0;
      end
      if (start_scan) begin
        cnt       <= '0;
        bfound[0] <= 1'b0;
        bfound[1] <= 1'b0;
        hfound    <= 1'b0;
      end else if (rd_vld && rd_slotv) begin
        if (take) begin
          bfound[rd_side] <= 1'b1;
          bprice[rd_side] <= rd_price;
          bage[rd_side]   <= age;
          bidx[rd_side]   <= rd_idx;
          brem[rd_side]   <= rd_rem;
          bowner[rd_side] <= rd_owner;
        end
        btot[rd_side] <= tot_new;
        if (hit) begin
          hfound <= 1'b1;
          hage   <= age;
          hidx   <= rd_idx;
        end
      end
      if (pop_cmd) begin
        cur   <= q_cmd;
        rem   <= q_cmd.qty;
        nfill <= '0;
        stat  <= ST_IGNORED;
        unique case (q_cmd.op)
          OP_LIMIT, OP_MARKET: phase <= PH_MATCH;
          OP_CANCEL:           phase <= PH_CANCEL;
          default:             phase <= PH_SUMMARY;
        endcase
      end
      if (do_trade) begin
        rem   <= rem - m;
        nfill <= nfill + 1'b1;
        if (brem[opp] == m) slot_valid[bidx[opp]] <= 1'b0;
      end
      if (do_finish) begin
        phase <= PH_SUMMARY;
        if (phase == PH_MATCH) begin
          stat <= fin_status;
        end else begin
          stat <= hfound ? ST_CANCELLED : ST_UNKNOWN;
          if (hfound) slot_valid[hidx] <= 1'b0;
        end
      end
      if (do_rest) begin
        slot_valid[free_idx] <= 1'b1;
        arrival_counter      <= arrival_counter + 1'b1;
      end
    end
  end

  // store reads and writes
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_side  <= mem_side[cnt[AW-1:0]];
      rd_price <= mem_price[cnt[AW-1:0]];
      rd_rem   <= mem_rem[cnt[AW-1:0]];
      rd_owner <= mem_owner[cnt[AW-1:0]];
      rd_arr   <= mem_arr[cnt[AW-1:0]];
    end
    if (do_trade) mem_rem[bidx[opp]] <= brem[opp] - m;
    if (do_rest) begin
      mem_side[free_idx]  <= cur.side;
      mem_price[free_idx] <= cur.price;
      mem_rem[free_idx]   <= rem;
      mem_owner[free_idx] <= cur.id;
      mem_arr[free_idx]   <= arrival_counter;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_trade || emit_sum) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_trade) begin
      kind           <= KIND_TRADE;
      trade_price    <= bprice[opp];
      trade_quantity <= m;
      resting_id     <= bowner[opp];
      taker_id       <= cur.id;
      trade_time     <= cur.ts;
      status         <= '0;
      best_bid       <= '0;
      best_ask       <= '0;
      bid_total      <= '0;
      ask_total      <= '0;
      last           <= 1'b0;
    end else if (emit_sum) begin
      kind           <= KIND_SUM;
      trade_price    <= '0;
      trade_quantity <= '0;
      resting_id     <= '0;
      taker_id       <= '0;
      trade_time     <= '0;
      status         <= stat;
      best_bid       <= bfound[0] ? bprice[0] : '0;
      bid_total      <= bfound[0] ? btot[0]   : '0;
      best_ask       <= bfound[1] ? bprice[1] : '1;
      ask_total      <= bfound[1] ? btot[1]   : '0;
      last           <= 1'b1;
    end
  end

endmodule

FILE: rtl/limit_order_book_matcher_core.sv
// A limit or market command scans the store once before each fill, once to find
//   no further fill and once more for its closing summary.
// The engine takes no new command until that summary has been sent.
// A two-entry command queue takes new items while the engine works.
// Reset clears the queue, valid bits, arrival counter and result register;
//   store contents need no clearing pass.
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Price-time priority order book: front queue plus scanning match engine.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core #(
  parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  mode,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  input  logic [31:0] order_id,
  input  logic [47:0] timestamp,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        kind,
  output logic [31:0] trade_price,
  output logic [31:0] trade_quantity,
  output logic [31:0] resting_id,
  output logic [31:0] taker_id,
  output logic [47:0] trade_time,
  output logic [2:0]  status,
  output logic [31:0] best_bid,
  output logic [31:0] best_ask,
  output logic [31:0] bid_total,
  output logic [31:0] ask_total,
  output logic        last
);
  import lobm_pkg::*;

  localparam int CW = $clog2(MAX_ORDERS+1);

  logic          q_valid;
  cmd_t          q_cmd;
  logic          q_pop;
  logic [CW-1:0] fill_count;

  lobm_front u_front (
    .clk, .rst, .cmd_valid, .cmd_stall, .mode, .side, .price, .quantity,
    .order_id, .timestamp, .q_valid, .q_cmd, .q_pop
  );

  lobm_engine #(.MAX_ORDERS(MAX_ORDERS)) u_engine (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .res_valid, .res_stall, .kind,
    .trade_price, .trade_quantity, .resting_id, .taker_id, .trade_time,
    .status, .best_bid, .best_ask, .bid_total, .ask_total, .last, .fill_count
  );

  a_trade_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_TRADE) |-> !last && (trade_quantity != '0))
    else $error("trade item malformed");

  a_sum_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_SUM) |-> (status <= ST_IGNORED) && last)
    else $error("summary status out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_ORDERS))
    else $error("too many fills for one command");

endmodule
